>>> design/btpf_pkg.sv
// Shared types, sizes and a helper function for the background tile pixel fetch block.
`default_nettype none

package btpf_pkg;

	// Video memory geometry: two byte banks, even and odd addresses.
	localparam int VRAM_DEPTH = 8192;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
	localparam int BANK_DEPTH = VRAM_DEPTH / 2;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);

	// Stream widths.
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 16;

	// Configuration port.
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Item kind carried in tuser.
	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	// Register index, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_MAP_SELECT  = 2'd0,
		REG_DATA_SELECT = 2'd1,
		REG_SCROLL_Y    = 2'd2,
		REG_SCROLL_X    = 2'd3
	} reg_idx_t;

	// Inverted grey level: (3 - c) * 85 is the two-bit complement repeated four times.
	function automatic logic [7:0] gray_of(input logic [1:0] color);
		gray_of = {4{~color}};
	endfunction

endpackage

`default_nettype wire

>>> design/background_tile_pixel_fetch_core.sv
// Top level of the background tile pixel fetch block: banked video memory and fetch pipeline.
// A pixel beat passes stage 1, the tile map read, the bit-plane read and the output register, in order.
// Throughput: one item per cycle while m_tready and s_tready allow; each pixel reads the tile map
// in one stage and both bit-plane bytes in the next, from an even and an odd byte bank with two
// read ports each. Reset: arst_n clears control state and registers, then the memory is cleared,
// one address of each bank per cycle, with s_tready low; configuration writes are taken throughout.
`default_nettype none

module background_tile_pixel_fetch_core
	import btpf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input stream.
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata: vram_offset[12:0], write_byte[20:13], pixel_x[28:21], pixel_y[36:29], zero pad.
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: kind (0 write, 1 pixel).
	input  wire logic                  s_tuser,
	// Result stream.
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata: color_index[1:0], gray_level[9:2], zero pad.
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// Configuration port.
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_AW-1:0]     paddr,
	input  wire logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]          prdata,
	output logic                       pready
);

	// Configuration registers.
	logic       map_select_q;
	logic       data_select_q;
	logic [7:0] scroll_y_q;
	logic [7:0] scroll_x_q;
	logic       cfg_write;
	reg_idx_t   cfg_idx;

	// Clearing sweep after reset.
	logic               clearing_q;
	logic [BANK_AW-1:0] clr_idx_q;

	// Video memory banks.
	logic [7:0] mem_even [BANK_DEPTH];
	logic [7:0] mem_odd  [BANK_DEPTH];

	// Stage 1: accepted item.
	logic               valid_s1;
	kind_t              kind_s1;
	logic [VRAM_AW-1:0] waddr_s1;
	logic [7:0]         wbyte_s1;
	logic [VRAM_AW-1:0] map_addr_s1;
	logic [2:0]         row_s1;
	logic [2:0]         bitsel_s1;

	// Stage 2: tile map bytes read.
	logic       valid_s2;
	logic       map_odd_sel_s2;
	logic [7:0] map_even_s2;
	logic [7:0] map_odd_s2;
	logic [2:0] row_s2;
	logic [2:0] bitsel_s2;

	// Stage 3: bit-plane bytes read.
	logic       valid_s3;
	logic [7:0] lo_s3;
	logic [7:0] hi_s3;
	logic [2:0] bitsel_s3;

	// Stage 4: output register.
	logic       valid_s4;
	logic [1:0] color_s4;
	logic [7:0] gray_s4;

	// Stage load enables, bubbles collapse.
	logic ld1, ld2, ld3, ld4;
	logic s_accept;

	// Input decode.
	logic [7:0] in_x, in_y, sx, sy;

	// Stage 2 address forming.
	logic [7:0]         tile_s2;
	logic               signed_hi_s2;
	logic [BANK_AW-1:0] row_idx_s2;

	// Memory write port.
	logic               wr_even, wr_odd;
	logic [BANK_AW-1:0] wr_idx;
	logic [7:0]         wr_data;
	logic               item_write;

	// Stage 3 colour pick.
	logic [2:0] bit_pos_s3;
	logic [1:0] color_s3;

	// Register port: always ready, write on the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign cfg_idx   = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_select_q  <= 1'b0;
			data_select_q <= 1'b0;
			scroll_y_q    <= 8'd0;
			scroll_x_q    <= 8'd0;
		end else if (cfg_write) begin
			unique case (cfg_idx)
				REG_MAP_SELECT:  map_select_q  <= pwdata[0];
				REG_DATA_SELECT: data_select_q <= pwdata[0];
				REG_SCROLL_Y:    scroll_y_q    <= pwdata[7:0];
				REG_SCROLL_X:    scroll_x_q    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_MAP_SELECT:  prdata = {{(APB_DW-1){1'b0}}, map_select_q};
			REG_DATA_SELECT: prdata = {{(APB_DW-1){1'b0}}, data_select_q};
			REG_SCROLL_Y:    prdata = {{(APB_DW-8){1'b0}}, scroll_y_q};
			REG_SCROLL_X:    prdata = {{(APB_DW-8){1'b0}}, scroll_x_q};
			default:         prdata = '0;
		endcase
	end

	// Clearing sweep: one address of both banks per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == BANK_AW'(BANK_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Load enables from the output end backwards.
	assign ld4      = !valid_s4 || m_tready;
	assign ld3      = !valid_s3 || ld4;
	assign ld2      = !valid_s2 || ld3;
	assign ld1      = !valid_s1 || ld2;
	assign s_tready = ld1 && !clearing_q;
	assign s_accept = s_tvalid && s_tready;

	// Scrolled position wraps at 256; map entry is base + row of tiles * 32 + tile column.
	assign in_x = s_tdata[28:21];
	assign in_y = s_tdata[36:29];
	assign sx   = in_x + scroll_x_q;
	assign sy   = in_y + scroll_y_q;

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ld1) begin
			valid_s1 <= s_accept;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1     <= kind_t'(s_tuser);
			waddr_s1    <= s_tdata[12:0];
			wbyte_s1    <= s_tdata[20:13];
			map_addr_s1 <= {2'b11, map_select_q, sy[7:3], sx[7:3]};
			row_s1      <= sy[2:0];
			bitsel_s1   <= sx[2:0];
		end
	end

	// Memory write port: the sweep, or a write beat as it leaves stage 1.
	assign item_write = valid_s1 && (kind_s1 == KIND_WRITE) && ld2;

	always_comb begin
		if (clearing_q) begin
			wr_even = 1'b1;
			wr_odd  = 1'b1;
			wr_idx  = clr_idx_q;
			wr_data = 8'd0;
		end else begin
			wr_even = item_write && !waddr_s1[0];
			wr_odd  = item_write && waddr_s1[0];
			wr_idx  = waddr_s1[VRAM_AW-1:1];
			wr_data = wbyte_s1;
		end
	end

	// Stage 2 forms the tile row address; signed mode sets bit 12 for tiles 0 to 127.
	assign tile_s2      = map_odd_sel_s2 ? map_odd_s2 : map_even_s2;
	assign signed_hi_s2 = !data_select_q && !tile_s2[7];
	assign row_idx_s2   = {signed_hi_s2, tile_s2, row_s2};

	// Even bank: map read for stage 2, low plane read for stage 3.
	always_ff @(posedge clk) begin
		if (wr_even) begin
			mem_even[wr_idx] <= wr_data;
		end
		if (ld2) begin
			map_even_s2 <= mem_even[map_addr_s1[VRAM_AW-1:1]];
		end
		if (ld3) begin
			lo_s3 <= mem_even[row_idx_s2];
		end
	end

	// Odd bank: map read for stage 2, high plane read for stage 3.
	always_ff @(posedge clk) begin
		if (wr_odd) begin
			mem_odd[wr_idx] <= wr_data;
		end
		if (ld2) begin
			map_odd_s2 <= mem_odd[map_addr_s1[VRAM_AW-1:1]];
		end
		if (ld3) begin
			hi_s3 <= mem_odd[row_idx_s2];
		end
	end

	// Stage 2 and 3 valids; only pixel beats go past stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ld2) begin
				valid_s2 <= valid_s1 && (kind_s1 == KIND_PIXEL);
			end
			if (ld3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// Stage 2 and 3 side payload.
	always_ff @(posedge clk) begin
		if (ld2) begin
			map_odd_sel_s2 <= map_addr_s1[0];
			row_s2         <= row_s1;
			bitsel_s2      <= bitsel_s1;
		end
		if (ld3) begin
			bitsel_s3 <= bitsel_s2;
		end
	end

	// Leftmost pixel is bit 7 of each plane byte.
	assign bit_pos_s3 = ~bitsel_s3;
	assign color_s3   = {hi_s3[bit_pos_s3], lo_s3[bit_pos_s3]};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (ld4) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld4 && valid_s3) begin
			color_s4 <= color_s3;
			gray_s4  <= gray_of(color_s3);
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {{(OUT_DATA_W-10){1'b0}}, gray_s4, color_s4};

endmodule

`default_nettype wire

>>> design/btpf_checker.sv
// Port-level checks for the background tile pixel fetch block, bound to its top level.
`default_nettype none

module btpf_checker
	import btpf_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata
);

	// A stalled result beat holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// The grey level always matches the colour it came from.
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[9:2] == gray_of(m_tdata[1:0]))
		else $error("grey level does not match colour");

	// Pad bits above the result fields stay zero.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_DATA_W-1:10] == '0)
		else $error("result pad bits not zero");

endmodule

bind background_tile_pixel_fetch_core btpf_checker u_btpf_checker (.*);

`default_nettype wire
